### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// All assertions sample on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, including during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/scsc_pkg.sv
package scsc_pkg;

    // Fixed field widths
    localparam int OP_W          = 2;
    localparam int SECTOR_W      = 32;
    localparam int SLOT_W        = 6;
    localparam int SLOTS_DEFAULT = 64;

    // Request operation codes (remaining code is answered with a result word with no hit or write-back)
    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SWEEP,
        ST_VREAD,
        ST_VWRITE,
        ST_RESP,
        ST_FL_RD,
        ST_FL_EMIT
    } state_t;

    // Tag RAM access from the sequencer
    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [SLOT_W-1:0]   addr;
        logic [SECTOR_W-1:0] wdata;
    } ram_req_t;

    // One result word
    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic                write_back;
        logic [SECTOR_W-1:0] evicted_sector;
        logic                last;
    } res_t;

endpackage

### hw/rtl/scsc_req_if.sv
interface scsc_req_if;
    import scsc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [SECTOR_W-1:0] sector;

    modport source (output valid, output op, output sector, input ready);
    modport sink   (input valid, input op, input sector, output ready);

endinterface

### hw/rtl/scsc_res_if.sv
interface scsc_res_if;
    import scsc_pkg::*;

    logic                valid;
    logic                ready;
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic                write_back;
    logic [SECTOR_W-1:0] evicted_sector;
    logic                last;

    modport source (output valid, output hit, output slot, output write_back,
                    output evicted_sector, output last, input ready);
    modport sink   (input valid, input hit, input slot, input write_back,
                    input evicted_sector, input last, output ready);

endinterface

### hw/rtl/scsc_tag_ram.sv
module scsc_tag_ram #(
    parameter int SLOTS = scsc_pkg::SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  scsc_pkg::ram_req_t            req,
    output logic [scsc_pkg::SECTOR_W-1:0] rdata
);
    import scsc_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    logic [SECTOR_W-1:0] tag_mem [SLOTS];
    logic [SECTOR_W-1:0] rdata_reg;

    // Single port (one address): a write and a registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            tag_mem[req.addr[IDX_W-1:0]] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= tag_mem[req.addr[IDX_W-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/scsc_ctrl.sv
`include "assert_macros.svh"

module scsc_ctrl #(
    parameter int SLOTS = scsc_pkg::SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    scsc_req_if.sink                      req,
    output logic                          res_valid,
    output scsc_pkg::res_t                res_o,
    input  logic                          res_ready,
    output scsc_pkg::ram_req_t            ram_req,
    input  logic [scsc_pkg::SECTOR_W-1:0] ram_rdata
);
    import scsc_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int OCC_W = $clog2(SLOTS + 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(SLOTS);
    localparam logic [OCC_W-1:0] OCC_LAST = OCC_W'(SLOTS - 1);

    state_t              state_reg, state_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [SLOTS-1:0]    refb_reg, refb_next;
    logic [OCC_W-1:0]    idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [SECTOR_W-1:0] sector_reg, sector_next;
    logic                rhit_reg, rhit_next;
    logic [IDX_W-1:0]    rslot_reg, rslot_next;
    logic                rwb_reg, rwb_next;
    logic [SECTOR_W-1:0] rsec_reg, rsec_next;
    logic                fl_last;
    logic                last_taken;
    logic                fl_done;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            refb_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            refb_reg  <= refb_next;
            pend_reg  <= pend_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pidx_reg   <= pidx_next;
        op_reg     <= op_next;
        sector_reg <= sector_next;
        rhit_reg   <= rhit_next;
        rslot_reg  <= rslot_next;
        rwb_reg    <= rwb_next;
        rsec_reg   <= rsec_next;
    end

    assign fl_last = ((idx_reg + OCC_W'(1)) == occ_reg);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        refb_next   = refb_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        op_next     = op_reg;
        sector_next = sector_reg;
        rhit_next   = rhit_reg;
        rslot_next  = rslot_reg;
        rwb_next    = rwb_reg;
        rsec_next   = rsec_reg;
        ram_req     = '0;
        res_valid   = 1'b0;
        res_o       = '0;
        req.ready   = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.op;
                    sector_next = req.sector;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    rhit_next   = 1'b0;
                    rslot_next  = '0;
                    rwb_next    = 1'b0;
                    rsec_next   = '0;
                    case (req.op)
                        OP_LOOKUP, OP_INSERT: state_next = ST_SEARCH;
                        OP_FLUSH:  state_next = (occ_reg == '0) ? ST_RESP : ST_FL_RD;
                        default:   state_next = ST_RESP;
                    endcase
                end
            end

            // Tag search: read slot i while comparing slot i-1
            ST_SEARCH:
            begin
                if (pend_reg && (ram_rdata == sector_reg))
                begin
                    rhit_next  = 1'b1;
                    rslot_next = pidx_reg;
                    pend_next  = 1'b0;
                    state_next = ST_RESP;
                end
                else if (idx_reg < occ_reg)
                begin
                    ram_req.rd_en = 1'b1;
                    ram_req.addr  = SLOT_W'(idx_reg[IDX_W-1:0]);
                    pend_next     = 1'b1;
                    pidx_next     = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + OCC_W'(1);
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else if (op_reg != OP_INSERT)
                begin
                    state_next = ST_RESP;
                end
                else if (occ_reg < OCC_FULL)
                begin
                    // Fill the next free slot
                    ram_req.wr_en = 1'b1;
                    ram_req.addr  = SLOT_W'(occ_reg[IDX_W-1:0]);
                    ram_req.wdata = sector_reg;
                    refb_next[occ_reg[IDX_W-1:0]] = 1'b1;
                    occ_next   = occ_reg + OCC_W'(1);
                    rslot_next = occ_reg[IDX_W-1:0];
                    state_next = ST_RESP;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_SWEEP;
                end
            end

            // Second-chance sweep from slot 0
            ST_SWEEP:
            begin
                if (!refb_reg[idx_reg[IDX_W-1:0]])
                begin
                    rslot_next = idx_reg[IDX_W-1:0];
                    state_next = ST_VREAD;
                end
                else
                begin
                    refb_next[idx_reg[IDX_W-1:0]] = 1'b0;
                    if (idx_reg == OCC_LAST)
                    begin
                        rslot_next = '0;
                        state_next = ST_VREAD;
                    end
                    else
                    begin
                        idx_next = idx_reg + OCC_W'(1);
                    end
                end
            end

            ST_VREAD:
            begin
                ram_req.rd_en = 1'b1;
                ram_req.addr  = SLOT_W'(rslot_reg);
                state_next    = ST_VWRITE;
            end

            // Victim's old tag is out; replace it
            ST_VWRITE:
            begin
                rsec_next     = ram_rdata;
                rwb_next      = 1'b1;
                ram_req.wr_en = 1'b1;
                ram_req.addr  = SLOT_W'(rslot_reg);
                ram_req.wdata = sector_reg;
                refb_next[rslot_reg] = 1'b1;
                state_next    = ST_RESP;
            end

            ST_RESP:
            begin
                res_valid            = 1'b1;
                res_o.hit            = rhit_reg;
                res_o.slot           = SLOT_W'(rslot_reg);
                res_o.write_back     = rwb_reg;
                res_o.evicted_sector = rsec_reg;
                res_o.last           = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_FL_RD:
            begin
                ram_req.rd_en = 1'b1;
                ram_req.addr  = SLOT_W'(idx_reg[IDX_W-1:0]);
                state_next    = ST_FL_EMIT;
            end

            // One write-back word per valid slot
            ST_FL_EMIT:
            begin
                res_valid            = 1'b1;
                res_o.slot           = SLOT_W'(idx_reg[IDX_W-1:0]);
                res_o.write_back     = 1'b1;
                res_o.evicted_sector = ram_rdata;
                res_o.last           = fl_last;
                if (res_ready)
                begin
                    if (fl_last)
                    begin
                        refb_next  = '0;
                        occ_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + OCC_W'(1);
                        state_next = ST_FL_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Final word of a request handed on
    assign last_taken = res_valid && res_ready && res_o.last;
    assign fl_done    = last_taken && (state_reg == ST_FL_EMIT);

    `ASSERT_CLK(a_occ_bound, occ_reg <= OCC_FULL, "occupancy above slot count")
    `ASSERT_CLK(a_last_idle, last_taken |=> (state_reg == ST_IDLE), "no idle after last word")
    `ASSERT_CLK(a_flush_empty, fl_done |=> (occ_reg == '0 && refb_reg == '0), "flush left entries")

endmodule

### hw/rtl/sector_cache_second_chance_unit.sv
// Second-chance tag and replacement engine for a fully associative sector cache.
// Request channel req carries op (lookup, insert, flush) and a sector number;
// result channel res returns hit, slot, write_back, evicted_sector and last.
// Both use valid/ready; a word moves when both are high at a clock edge.
// One request is in work at a time: req.ready is high only while idle, so the
// next request can be taken in the cycle after the last result word leaves the sequencer.
// Steps per operation, from acceptance to the result word entering the output register:
//   lookup / insert hit or miss: tag search reads
//   one slot per cycle from the single-port tag RAM, compare in the cycle after the read.
//   insert into a full cache: search, then a
//   one-slot-per-cycle reference-bit sweep, victim read and rewrite.
//   flush: one write-back word per valid slot, last on the final (empty cache: one plain last word).
// The output register holds a word until res.ready; while it is full and
// stalled the sequencer waits, and no result is lost or repeated.
// Reset (rst_n low, asynchronous) empties the cache and clears reference bits;
// tag contents are not cleared and only valid slots are ever read.
module sector_cache_second_chance_unit #(
    parameter int SLOTS = scsc_pkg::SLOTS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    scsc_req_if.sink   req,
    scsc_res_if.source res
);
    import scsc_pkg::*;

    ram_req_t            ram_req;
    logic [SECTOR_W-1:0] ram_rdata;
    res_t                ctrl_res;
    logic                ctrl_valid;
    logic                stage_ready;
    logic                out_valid_reg;
    res_t                out_reg;

    scsc_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (ctrl_valid),
        .res_o     (ctrl_res),
        .res_ready (stage_ready),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    scsc_tag_ram #(.SLOTS(SLOTS)) u_tag_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // Output register
    assign stage_ready = !out_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_ready)
        begin
            out_valid_reg <= ctrl_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready && ctrl_valid)
        begin
            out_reg <= ctrl_res;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.hit            = out_reg.hit;
    assign res.slot           = out_reg.slot;
    assign res.write_back     = out_reg.write_back;
    assign res.evicted_sector = out_reg.evicted_sector;
    assign res.last           = out_reg.last;

endmodule
